FILE: src/c_like_token_scanner_core_defines.svh
// Assertion macros shared by the token scanner RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef C_LIKE_TOKEN_SCANNER_CORE_DEFINES_SVH
`define C_LIKE_TOKEN_SCANNER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CTLS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("token scanner check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

FILE: src/ctls_pkg.sv
// Shared types, codes and character classes for the token scanner.
// No dependencies; used by every RTL module.
package ctls_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TOKEN_LEN_DEF = 64;
    localparam int OFFSET_BITS_DEF   = 24;

    // Fixed widths of the result fields
    localparam int KIND_W  = 6;
    localparam int START_W = 24;
    localparam int LEN_W   = 7;

    // Result queue depth: one input byte can add two results
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_EOF, KIND_LPAREN, KIND_RPAREN, KIND_LBRACKET, KIND_RBRACKET,
        KIND_LBRACE, KIND_RBRACE, KIND_COMMA, KIND_COLON, KIND_SEMI, KIND_DOT,
        KIND_ASSIGN, KIND_EQ, KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH,
        KIND_PERCENT, KIND_AMP, KIND_ANDAND, KIND_BAR, KIND_OROR, KIND_CARET,
        KIND_TILDE, KIND_BANG, KIND_NE, KIND_HASH, KIND_BACKSLASH, KIND_LT,
        KIND_SHL, KIND_LE, KIND_GT, KIND_SHR, KIND_GE, KIND_IDENT,
        KIND_NUMBER, KIND_STRING, KIND_CHAR, KIND_UNKNOWN
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_CHAR, MODE_OP
    } scan_mode_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_EQ, OP_AMP, OP_BAR, OP_BANG, OP_LT, OP_GT
    } op_code_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_payload_t;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [START_W-1:0] start_offset;
        logic [LEN_W-1:0]   token_length;
        logic               too_long;
        logic               last_of_run;
    } result_t;

    // Results produced by one accepted request, in emission order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
               c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic is_letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_decimal_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Single-byte punctuation; KIND_EOF means not punctuation
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            ":":     k = KIND_COLON;
            ";":     k = KIND_SEMI;
            ".":     k = KIND_DOT;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "%":     k = KIND_PERCENT;
            "^":     k = KIND_CARET;
            "~":     k = KIND_TILDE;
            "#":     k = KIND_HASH;
            "\\":    k = KIND_BACKSLASH;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    // Bytes that may start a two-byte operator
    function automatic op_code_t op_code(input logic [7:0] c);
        op_code_t op;
        case (c)
            "=":     op = OP_EQ;
            "&":     op = OP_AMP;
            "|":     op = OP_BAR;
            "!":     op = OP_BANG;
            "<":     op = OP_LT;
            ">":     op = OP_GT;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic kind_t op_single_kind(input op_code_t op);
        kind_t k;
        case (op)
            OP_EQ:   k = KIND_ASSIGN;
            OP_AMP:  k = KIND_AMP;
            OP_BAR:  k = KIND_BAR;
            OP_BANG: k = KIND_BANG;
            OP_LT:   k = KIND_LT;
            OP_GT:   k = KIND_GT;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    // Two-byte operator formed by pending op and c; KIND_EOF if none
    function automatic kind_t op_double_kind(input op_code_t op, input logic [7:0] c);
        kind_t k;
        k = KIND_EOF;
        case (op)
            OP_EQ:   if (c == "=") k = KIND_EQ;
            OP_AMP:  if (c == "&") k = KIND_ANDAND;
            OP_BAR:  if (c == "|") k = KIND_OROR;
            OP_BANG: if (c == "=") k = KIND_NE;
            OP_LT:
            begin
                if (c == "<")      k = KIND_SHL;
                else if (c == "=") k = KIND_LE;
            end
            OP_GT:
            begin
                if (c == ">")      k = KIND_SHR;
                else if (c == "=") k = KIND_GE;
            end
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

FILE: src/ctls_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from ctls_pkg at instantiation.
interface ctls_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/c_like_token_scanner_core.sv
// Results are registered in the result queue and offered from it in order.
// Throughput: one byte per cycle; a byte that ends a token and starts another
// adds two results, and the four-entry result queue drains one per cycle while
// out ready is high, so input ready drops while fewer than two slots are free.
// Reset (rst_n low, async): scanner idle, offset zero, result queue empty.
module c_like_token_scanner_core #(
    parameter int MAX_TOKEN_LEN = ctls_pkg::MAX_TOKEN_LEN_DEF,
    parameter int OFFSET_BITS   = ctls_pkg::OFFSET_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    ctls_stream_if.sink   in_chan,
    ctls_stream_if.source out_chan
);
    logic                room;
    logic                accept;
    ctls_pkg::step_out_t step;

    // Request accepted when the queue can absorb two results
    assign in_chan.ready = room;
    assign accept        = in_chan.valid && room;

    ctls_scan_step #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .req   (in_chan.data),
        .step  (step)
    );

    ctls_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .step     (step),
        .room     (room),
        .out_valid(out_chan.valid),
        .out_ready(out_chan.ready),
        .out_data (out_chan.data)
    );

endmodule

FILE: src/ctls_scan_step.sv
// Scanner state and per-byte transition: up to two results per request.
// Depends on ctls_pkg.
module ctls_scan_step #(
    parameter int MAX_TOKEN_LEN = ctls_pkg::MAX_TOKEN_LEN_DEF,
    parameter int OFFSET_BITS   = ctls_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ctls_pkg::in_payload_t req,
    output ctls_pkg::step_out_t   step
);
    localparam int CW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int SW = ctls_pkg::START_W;
    localparam int LW = ctls_pkg::LEN_W;

    ctls_pkg::scan_mode_t   mode_reg, mode_next;
    ctls_pkg::op_code_t     pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;

    logic                   pre_v, sec_v;
    ctls_pkg::result_t      pre_res, sec_res;
    ctls_pkg::result_t      tok_res;
    ctls_pkg::kind_t        dk;
    ctls_pkg::kind_t        pk;
    ctls_pkg::op_code_t     oc;
    logic [7:0]             c;
    logic                   rescan;

    // Transition for one byte or the end marker
    always_comb
    begin
        c           = req.char_byte;
        pk          = ctls_pkg::punct_kind(c);
        oc          = ctls_pkg::op_code(c);
        dk          = ctls_pkg::op_double_kind(pend_reg, c);
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        pre_v       = 1'b0;
        sec_v       = 1'b0;
        rescan      = 1'b0;
        sec_res     = '0;

        // Pending identifier, number or literal as a result
        tok_res.token_kind   = ctls_pkg::KIND_IDENT;
        case (mode_reg)
            ctls_pkg::MODE_NUMBER: tok_res.token_kind = ctls_pkg::KIND_NUMBER;
            ctls_pkg::MODE_STRING: tok_res.token_kind = ctls_pkg::KIND_STRING;
            ctls_pkg::MODE_CHAR:   tok_res.token_kind = ctls_pkg::KIND_CHAR;
            default:               tok_res.token_kind = ctls_pkg::KIND_IDENT;
        endcase
        tok_res.start_offset = SW'(start_reg);
        tok_res.token_length = LW'(count_reg);
        tok_res.too_long     = ovf_reg;
        tok_res.last_of_run  = 1'b0;

        // Lone operator by default; overridden below where needed
        pre_res              = tok_res;
        pre_res.token_kind   = ctls_pkg::op_single_kind(pend_reg);
        pre_res.token_length = LW'(1);
        pre_res.too_long     = 1'b0;

        if (req.end_of_input)
        begin
            // Flush pending identifier, number or operator, then eof; scanner restarts
            if (mode_reg == ctls_pkg::MODE_IDENT || mode_reg == ctls_pkg::MODE_NUMBER)
            begin
                pre_v   = 1'b1;
                pre_res = tok_res;
            end
            else if (mode_reg == ctls_pkg::MODE_OP)
            begin
                pre_v = 1'b1;
            end
            sec_v                = 1'b1;
            sec_res.token_kind   = ctls_pkg::KIND_EOF;
            sec_res.start_offset = SW'(offset_reg);
            mode_next   = ctls_pkg::MODE_IDLE;
            pend_next   = ctls_pkg::OP_NONE;
            offset_next = '0;
            start_next  = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            case (mode_reg)
                ctls_pkg::MODE_IDENT, ctls_pkg::MODE_NUMBER:
                begin
                    if (ctls_pkg::is_decimal_byte(c) || (mode_reg == ctls_pkg::MODE_IDENT &&
                        (ctls_pkg::is_letter_byte(c) || c == "_")))
                    begin
                        if (count_reg < CW'(MAX_TOKEN_LEN)) count_next = count_reg + CW'(1);
                        else                                 ovf_next   = 1'b1;
                    end
                    else
                    begin
                        pre_v   = 1'b1;
                        pre_res = tok_res;
                        rescan  = 1'b1;
                    end
                end
                ctls_pkg::MODE_STRING, ctls_pkg::MODE_CHAR:
                begin
                    if ((mode_reg == ctls_pkg::MODE_STRING && c == "\"") ||
                        (mode_reg == ctls_pkg::MODE_CHAR && c == "'"))
                    begin
                        pre_v     = 1'b1;
                        pre_res   = tok_res;
                        mode_next = ctls_pkg::MODE_IDLE;
                    end
                    else if (count_reg < CW'(MAX_TOKEN_LEN))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ctls_pkg::MODE_OP:
                begin
                    pre_v     = 1'b1;
                    pend_next = ctls_pkg::OP_NONE;
                    if (dk != ctls_pkg::KIND_EOF)
                    begin
                        pre_res.token_kind   = dk;
                        pre_res.token_length = LW'(2);
                        mode_next            = ctls_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            // Fresh scan of the byte from the idle mode
            if (rescan)
            begin
                mode_next            = ctls_pkg::MODE_IDLE;
                sec_res.start_offset = SW'(offset_reg);
                sec_res.token_length = LW'(1);
                if (ctls_pkg::is_space(c))
                begin
                    sec_v = 1'b0;
                end
                else if (pk != ctls_pkg::KIND_EOF)
                begin
                    sec_v              = 1'b1;
                    sec_res.token_kind = pk;
                end
                else if (oc != ctls_pkg::OP_NONE || ctls_pkg::is_letter_byte(c) || c == "_" ||
                         ctls_pkg::is_decimal_byte(c) || c == "\"" || c == "'")
                begin
                    start_next = offset_reg;
                    ovf_next   = 1'b0;
                    pend_next  = oc;
                    count_next = CW'(1);
                    if (oc != ctls_pkg::OP_NONE)
                        mode_next = ctls_pkg::MODE_OP;
                    else if (ctls_pkg::is_decimal_byte(c))
                        mode_next = ctls_pkg::MODE_NUMBER;
                    else if (c == "\"")
                    begin
                        mode_next  = ctls_pkg::MODE_STRING;
                        count_next = '0;
                    end
                    else if (c == "'")
                    begin
                        mode_next  = ctls_pkg::MODE_CHAR;
                        count_next = '0;
                    end
                    else
                        mode_next = ctls_pkg::MODE_IDENT;
                end
                else
                begin
                    sec_v              = 1'b1;
                    sec_res.token_kind = ctls_pkg::KIND_UNKNOWN;
                end
            end
            offset_next = offset_reg + OFFSET_BITS'(1);
        end

        // Pack results in order, marking the last one
        pre_res.last_of_run = !sec_v;
        sec_res.last_of_run = 1'b1;
        step.count  = {1'b0, pre_v} + {1'b0, sec_v};
        step.first  = pre_v ? pre_res : sec_res;
        step.second = sec_res;
    end

    // Scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ctls_pkg::MODE_IDLE;
            pend_reg   <= ctls_pkg::OP_NONE;
            offset_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

FILE: src/ctls_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
// Depends on ctls_pkg and c_like_token_scanner_core_defines.svh.
`include "c_like_token_scanner_core_defines.svh"

module ctls_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ctls_pkg::step_out_t step,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output ctls_pkg::result_t   out_data
);
    localparam int DEPTH = ctls_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ctls_pkg::result_t mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        n_push;
    logic              pop;

    // Pointer and occupancy update
    always_comb
    begin
        n_push      = push ? step.count : 2'd0;
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(n_push) - CW'(pop);
    end

    assign room      = count_reg <= CW'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];

    // Storage, written in emission order
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0) mem[wr_ptr_reg] <= step.first;
        if (n_push == 2'd2) mem[wr_ptr_reg + PW'(1)] <= step.second;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CTLS_ASSERT_ALWAYS(a_no_overflow, (32'(count_reg) + 32'(n_push)) <= DEPTH)
    `CTLS_ASSERT_ALWAYS(a_ptr_match, PW'(count_reg) == PW'(wr_ptr_reg - rd_ptr_reg))
    `CTLS_ASSERT_NEXT(a_pop_drains, pop && n_push == 2'd0, count_reg == $past(count_reg) - CW'(1))

endmodule
